// ===== rtl/rtty_pkg.sv =====
`default_nettype none

package rtty_pkg;

  // default sizes
  localparam int MAX_BIT_SAMPLES_DEF = 64;
  localparam int TIME_FRAC_BITS_DEF  = 8;

  // register and field widths
  localparam int CFG_W   = 15;
  localparam int QUAL_W  = 16;
  localparam int CODE_W  = 5;
  localparam int ASCII_W = 7;
  localparam logic [CFG_W-1:0] BIT_LENGTH_RST = 15'd2816;

  // ita2 control codes
  localparam logic [CODE_W-1:0] CODE_FIGS  = 5'h1B;
  localparam logic [CODE_W-1:0] CODE_LTRS  = 5'h1F;
  localparam logic [CODE_W-1:0] CODE_SPACE = 5'h04;

  // quality filter constants, q0.16
  localparam logic [QUAL_W-1:0] Q_GAIN = 16'd9830;
  localparam logic [QUAL_W-1:0] Q_LEAD = 16'd13107;
  localparam logic [QUAL_W-1:0] Q_HALF = 16'd32768;
  localparam logic [QUAL_W-1:0] Q_ONE  = 16'd65535;

  localparam logic [ASCII_W-1:0] ASCII_NONE  = 7'h00;
  localparam logic [ASCII_W-1:0] ASCII_SPACE = 7'h20;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2
  } phase_t;

  // per-framer status for one step
  typedef struct packed {
    logic                framed;
    logic [CODE_W-1:0]   code;
    logic [QUAL_W-1:0]   quality;
  } framer_stat_t;

  function automatic logic [ASCII_W-1:0] ltrs_char(input logic [CODE_W-1:0] c);
    logic [ASCII_W-1:0] r;
    case (c)
      5'h01: r = 7'h45;  5'h02: r = 7'h20;  5'h03: r = 7'h41;
      5'h04: r = 7'h20;  5'h05: r = 7'h53;  5'h06: r = 7'h49;  5'h07: r = 7'h55;
      5'h08: r = 7'h20;  5'h09: r = 7'h44;  5'h0A: r = 7'h52;  5'h0B: r = 7'h4A;
      5'h0C: r = 7'h4E;  5'h0D: r = 7'h46;  5'h0E: r = 7'h43;  5'h0F: r = 7'h4B;
      5'h10: r = 7'h54;  5'h11: r = 7'h5A;  5'h12: r = 7'h4C;  5'h13: r = 7'h57;
      5'h14: r = 7'h48;  5'h15: r = 7'h59;  5'h16: r = 7'h50;  5'h17: r = 7'h51;
      5'h18: r = 7'h4F;  5'h19: r = 7'h42;  5'h1A: r = 7'h47;
      5'h1C: r = 7'h4D;  5'h1D: r = 7'h58;  5'h1E: r = 7'h56;
      default: r = ASCII_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [ASCII_W-1:0] figs_char(input logic [CODE_W-1:0] c);
    logic [ASCII_W-1:0] r;
    case (c)
      5'h01: r = 7'h33;  5'h02: r = 7'h20;  5'h03: r = 7'h2D;
      5'h04: r = 7'h20;  5'h06: r = 7'h38;  5'h07: r = 7'h37;
      5'h08: r = 7'h20;  5'h09: r = 7'h24;  5'h0A: r = 7'h34;  5'h0B: r = 7'h27;
      5'h0C: r = 7'h2C;  5'h0D: r = 7'h21;  5'h0E: r = 7'h3A;  5'h0F: r = 7'h28;
      5'h10: r = 7'h35;  5'h11: r = 7'h22;  5'h12: r = 7'h29;  5'h13: r = 7'h32;
      5'h14: r = 7'h23;  5'h15: r = 7'h36;  5'h16: r = 7'h30;  5'h17: r = 7'h31;
      5'h18: r = 7'h39;  5'h19: r = 7'h3F;  5'h1A: r = 7'h26;
      5'h1C: r = 7'h2E;  5'h1D: r = 7'h2F;  5'h1E: r = 7'h3B;
      default: r = ASCII_NONE;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rtty_framer.sv =====
`default_nettype none

module rtty_framer import rtty_pkg::*; #(
  parameter int MAX_BIT_SAMPLES = MAX_BIT_SAMPLES_DEF,
  parameter int TIME_FRAC_BITS  = TIME_FRAC_BITS_DEF,
  parameter int LEN_W           = $clog2(MAX_BIT_SAMPLES) + TIME_FRAC_BITS + 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             mark,
  input  wire logic [LEN_W-1:0] len,
  output framer_stat_t          stat
);

  localparam int TIME_CAP_I = 7 * (MAX_BIT_SAMPLES << TIME_FRAC_BITS);
  localparam int TIME_W     = $clog2(TIME_CAP_I + 1);
  localparam int CMP_W      = LEN_W + 5;
  localparam logic [TIME_W-1:0] TIME_CAP   = TIME_W'(TIME_CAP_I);
  localparam logic [TIME_W-1:0] SAMPLE_ONE = TIME_W'(1 << TIME_FRAC_BITS);

  phase_t               phase, phase_next;
  logic [TIME_W-1:0]    tcount, tcount_next;
  logic [2:0]           idx, idx_next;
  logic [CODE_W-1:0]    code, code_next;
  logic [QUAL_W-1:0]    quality, quality_next;
  logic                 last_level;
  logic                 framed;

  // time after this sample, saturating
  logic [TIME_W-1:0]    t_tick;
  logic [CMP_W-1:0]     twice;
  logic [CMP_W-1:0]     len_ext;
  logic [CMP_W-1:0]     bit_point;
  logic [4:0]           factor;
  logic [30:0]          up_prod;
  logic [30:0]          dn_prod;

  assign t_tick    = (tcount < TIME_CAP) ? tcount + SAMPLE_ONE : tcount;
  assign twice     = CMP_W'({t_tick, 1'b0});
  assign len_ext   = CMP_W'(len);
  assign factor    = 5'd3 + {1'b0, idx, 1'b0};
  assign bit_point = CMP_W'(len_ext * CMP_W'(factor));

  // quality filter steps toward one or zero
  assign up_prod = 31'(Q_GAIN) * 31'(Q_ONE - quality) + 31'(Q_HALF);
  assign dn_prod = 31'(Q_GAIN) * 31'(quality) + 31'(Q_HALF);

  // frame sequencing
  always_comb begin
    phase_next   = phase;
    tcount_next  = tcount;
    idx_next     = idx;
    code_next    = code;
    quality_next = quality;
    framed       = 1'b0;
    case (phase)
      PH_START: begin
        tcount_next = t_tick;
        if (twice >= len_ext) begin
          if (!mark) begin
            phase_next = PH_DATA;
            idx_next   = 3'd0;
            code_next  = '0;
          end else begin
            phase_next = PH_HUNT;
          end
        end
      end
      PH_DATA: begin
        tcount_next = t_tick;
        if (twice >= bit_point) begin
          if (idx < 3'd5) begin
            if (mark) begin
              code_next = code | (CODE_W'(1) << idx);
            end
            idx_next = idx + 3'd1;
          end else begin
            if (mark) begin
              quality_next = quality + QUAL_W'(up_prod[30:16]);
              framed       = 1'b1;
            end else begin
              quality_next = quality - QUAL_W'(dn_prod[30:16]);
            end
            phase_next = PH_HUNT;
          end
        end
      end
      default: begin
        phase_next = PH_HUNT;
        if (last_level && !mark) begin
          phase_next  = PH_START;
          tcount_next = '0;
        end
      end
    endcase
  end

  // framer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      tcount     <= '0;
      idx        <= 3'd0;
      code       <= '0;
      quality    <= '0;
      last_level <= 1'b1;
    end else if (en) begin
      phase      <= phase_next;
      tcount     <= tcount_next;
      idx        <= idx_next;
      code       <= code_next;
      quality    <= quality_next;
      last_level <= mark;
    end
  end

  assign stat.framed  = framed;
  assign stat.code    = code;
  assign stat.quality = quality_next;

endmodule

`default_nettype wire

// ===== rtl/rtty_decode.sv =====
`default_nettype none

module rtty_decode import rtty_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                en,
  input  wire logic                gate,
  input  wire framer_stat_t        stat0,
  input  wire framer_stat_t        stat1,
  output logic                     ch_valid,
  output logic [ASCII_W-1:0]       ch_ascii,
  output logic                     polarity,
  output logic [QUAL_W-1:0]        quality
);

  logic               elected, elected_next;
  logic               figs, figs_next;
  logic               last_space, last_space_next;
  framer_stat_t       st_el;
  logic [ASCII_W-1:0] c;
  logic [QUAL_W-1:0]  q_el, q_ot;

  assign st_el = elected ? stat1 : stat0;
  assign q_el  = elected ? stat1.quality : stat0.quality;
  assign q_ot  = elected ? stat0.quality : stat1.quality;

  // letters/figures decode, space collapse, then polarity election
  always_comb begin
    elected_next    = elected;
    figs_next       = figs;
    last_space_next = last_space;
    ch_valid        = 1'b0;
    ch_ascii        = ASCII_NONE;
    c               = ASCII_NONE;
    if (st_el.framed && gate) begin
      if (st_el.code == CODE_LTRS) begin
        figs_next = 1'b0;
      end else if (st_el.code == CODE_FIGS) begin
        figs_next = 1'b1;
      end else begin
        c = figs ? figs_char(st_el.code) : ltrs_char(st_el.code);
        if (st_el.code == CODE_SPACE) begin
          figs_next = 1'b0;
        end
      end
      if (c != ASCII_NONE) begin
        if (c == ASCII_SPACE) begin
          if (!last_space) begin
            last_space_next = 1'b1;
            ch_valid        = 1'b1;
            ch_ascii        = c;
          end
        end else begin
          last_space_next = 1'b0;
          ch_valid        = 1'b1;
          ch_ascii        = c;
        end
      end
    end
    if (({1'b0, q_ot} > ({1'b0, q_el} + {1'b0, Q_LEAD})) && (q_ot > Q_HALF)) begin
      elected_next = ~elected;
      figs_next    = 1'b0;
    end
  end

  assign polarity = elected_next;
  assign quality  = elected_next ? stat1.quality : stat0.quality;

  // shared decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      elected    <= 1'b0;
      figs       <= 1'b0;
      last_space <= 1'b0;
    end else if (en) begin
      elected    <= elected_next;
      figs       <= figs_next;
      last_space <= last_space_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rtty_uart_ita2_decoder.sv =====
// RTTY ITA2 receiver with automatic polarity.
// Input channel (in_valid/in_ready) carries one sliced sample per beat:
// mark_sample and char_gate. Output channel (out_valid/out_ready) carries
// exactly one result beat per input beat: char_valid/char_ascii, the
// elected polarity and that framer's frame quality.
// A beat accepted into the sample register is stepped into the result register
// once the result register is free, and its result is then offered.
// Throughput: one beat per cycle unless the receiver stalls, set by the single
// pass through the two framers and the decoder between sample and result register.
// cfg_we/cfg_data write bit_length (samples per bit, unsigned Q7.8) in the same
// cycle; write it only while the block is idle.
// Reset: both framers hunt for a start edge, quality is zero, normal
// polarity, letters shift, bit length 2816.
// When the receiver stalls the result register holds; one more sample is
// held in the input register, then in_ready drops until out_ready returns.
`default_nettype none

module rtty_uart_ita2_decoder import rtty_pkg::*; #(
  parameter int MAX_BIT_SAMPLES = MAX_BIT_SAMPLES_DEF,
  parameter int TIME_FRAC_BITS  = TIME_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [CFG_W-1:0]   cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               mark_sample,
  input  wire logic               char_gate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    char_valid,
  output logic [ASCII_W-1:0]      char_ascii,
  output logic                    reversed_polarity,
  output logic [QUAL_W-1:0]       frame_quality
);

  localparam int LEN_W    = $clog2(MAX_BIT_SAMPLES) + TIME_FRAC_BITS + 1;
  localparam int BL_MIN_I = 2 << TIME_FRAC_BITS;
  localparam int BL_MAX_I = MAX_BIT_SAMPLES << TIME_FRAC_BITS;

  logic [CFG_W-1:0]   bit_length;
  logic [31:0]        bl_ext;
  logic [LEN_W-1:0]   len;
  logic               s1_valid;
  logic               s1_mark;
  logic               s1_gate;
  logic               out_free;
  logic               advance;
  framer_stat_t       stat0, stat1;
  logic               d_valid;
  logic [ASCII_W-1:0] d_ascii;
  logic               d_pol;
  logic [QUAL_W-1:0]  d_qual;

  // bit length register
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_length <= BIT_LENGTH_RST;
    end else if (cfg_we) begin
      bit_length <= cfg_data;
    end
  end

  // clamp bit length to the supported range
  assign bl_ext = 32'(bit_length);
  always_comb begin
    if (bl_ext < 32'(BL_MIN_I)) begin
      len = LEN_W'(BL_MIN_I);
    end else if (bl_ext > 32'(BL_MAX_I)) begin
      len = LEN_W'(BL_MAX_I);
    end else begin
      len = LEN_W'(bl_ext);
    end
  end

  // pipeline handshake
  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  // sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_mark <= mark_sample;
      s1_gate <= char_gate;
    end
  end

  // framers on the sample and on its inverse
  rtty_framer #(
    .MAX_BIT_SAMPLES (MAX_BIT_SAMPLES),
    .TIME_FRAC_BITS  (TIME_FRAC_BITS),
    .LEN_W           (LEN_W)
  ) u_framer0 (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .mark (s1_mark),
    .len  (len),
    .stat (stat0)
  );

  rtty_framer #(
    .MAX_BIT_SAMPLES (MAX_BIT_SAMPLES),
    .TIME_FRAC_BITS  (TIME_FRAC_BITS),
    .LEN_W           (LEN_W)
  ) u_framer1 (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .mark (~s1_mark),
    .len  (len),
    .stat (stat1)
  );

  // character decode and polarity election
  rtty_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .gate     (s1_gate),
    .stat0    (stat0),
    .stat1    (stat1),
    .ch_valid (d_valid),
    .ch_ascii (d_ascii),
    .polarity (d_pol),
    .quality  (d_qual)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      char_valid        <= d_valid;
      char_ascii        <= d_ascii;
      reversed_polarity <= d_pol;
      frame_quality     <= d_qual;
    end
  end

endmodule

`default_nettype wire
